// ===== rtl/complex_coordinate_converter_assert.svh =====
// Assertion macros used by the converter checker.
`ifndef COMPLEX_COORDINATE_CONVERTER_ASSERT_SVH
`define COMPLEX_COORDINATE_CONVERTER_ASSERT_SVH

// Check that cons follows whenever ante holds, outside reset.
`define CCC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("converter implication check failed");

// Check that cond holds at every clock edge outside reset.
`define CCC_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("converter invariant check failed");

`endif

// ===== rtl/ccc_pkg.sv =====
// Shared types, constants and the arctangent table of the coordinate converter.
`timescale 1ns / 1ps

package ccc_pkg;

  localparam int FRAC = 14;
  localparam int XW = 34;
  localparam int ZW = 32;
  localparam int PW = 49;
  localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

  localparam logic FUNC_POLAR = 1'b0;
  localparam logic FUNC_RECT = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic                 func;
    logic                 bypass;
    logic signed [15:0]   im;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [ZW-1:0]        z;
  } ccc_stage_t;

  function automatic logic [ZW-1:0] atan_angle(input logic [4:0] idx);
    logic [ZW-1:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      5'd24:   a = 32'h00000029;
      5'd25:   a = 32'h00000014;
      5'd26:   a = 32'h0000000A;
      5'd27:   a = 32'h00000005;
      5'd28:   a = 32'h00000003;
      5'd29:   a = 32'h00000001;
      5'd30:   a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/ccc_stage.sv =====
// One registered micro-rotation of the converter pipeline.
`timescale 1ns / 1ps

module ccc_stage import ccc_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  ccc_stage_t d,
  output ccc_stage_t q
);

  logic signed [XW-1:0] x_sh;
  logic signed [XW-1:0] y_sh;
  logic [ZW-1:0]        angle;
  logic                 plus;
  ccc_stage_t           q_next;

  always_comb begin
    x_sh = $signed(d.x) >>> STAGE;
    y_sh = $signed(d.y) >>> STAGE;
    angle = atan_angle(5'(STAGE));
    plus = (d.func == FUNC_POLAR) ? !d.y[XW-1] : d.z[ZW-1];
    q_next = d;
    if (plus) begin
      q_next.x = d.x + y_sh;
      q_next.y = d.y - x_sh;
      q_next.z = d.z + angle;
    end else begin
      q_next.x = d.x - y_sh;
      q_next.y = d.y + x_sh;
      q_next.z = d.z - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

// ===== rtl/complex_coordinate_converter.sv =====
// Top level of the pipelined rectangular/polar coordinate converter.
`timescale 1ns / 1ps

// Takes one transaction per clock: busy is always low, and each result shows on
// result_a/result_b for one cycle with done high. Each transaction passes
// through an input multiply stage, a range-reduction stage, the ITERATIONS
// registered micro-rotation stages, a gain multiply stage and the output
// register. The receiver cannot stall; results leave in the order the
// transactions came in.
module complex_coordinate_converter import ccc_pkg::*; #(
  parameter int ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic signed [15:0] operand_a,
  input  logic signed [15:0] operand_b,
  output logic               done,
  output logic signed [16:0] result_a,
  output logic signed [16:0] result_b
);

  localparam int MAG_SHIFT = 32 + FRAC;

  logic               s0_valid;
  logic               s0_func;
  logic signed [15:0] s0_a;
  logic signed [15:0] s0_b;
  logic signed [PW-1:0] s0_prod;

  logic signed [XW-1:0] re_scaled;
  logic signed [XW-1:0] im_scaled;
  logic signed [PW-1:0] rot_sum;
  logic signed [XW-1:0] rot_x;
  ccc_stage_t           s1_next;

  ccc_stage_t pipe [ITERATIONS+1];
  ccc_stage_t fin;

  logic                 p1_valid;
  logic                 p1_func;
  logic                 p1_bypass;
  logic signed [15:0]   p1_im;
  logic [63:0]          p1_mag;
  logic [15:0]          p1_ang;
  logic signed [16:0]   p1_re;
  logic signed [16:0]   p1_imag;

  logic [ZW-1:0]        ang_sum;
  logic signed [XW-1:0] re_sum;
  logic signed [XW-1:0] im_sum;
  logic signed [XW-1:0] re_sh;
  logic signed [XW-1:0] im_sh;

  logic [63:0]          mag_sum;
  logic signed [16:0]   im_ext;
  logic signed [16:0]   byp_a;
  logic signed [16:0]   byp_b;
  logic signed [16:0]   result_a_next;
  logic signed [16:0]   result_b_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    s0_func <= func;
    s0_a <= operand_a;
    s0_b <= operand_b;
    s0_prod <= operand_a * $signed({1'b0, GAIN_Q32});
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
  end

  always_comb begin
    re_scaled = XW'(s0_a) <<< FRAC;
    im_scaled = XW'(s0_b) <<< FRAC;
    rot_sum = s0_prod + $signed(PW'(1) << (31 - FRAC));
    rot_x = XW'(rot_sum >>> (32 - FRAC));
    s1_next.valid = s0_valid;
    s1_next.func = s0_func;
    s1_next.bypass = (s0_func == FUNC_POLAR) && (s0_a == 16'sd0);
    s1_next.im = s0_b;
    if (s0_func == FUNC_POLAR) begin
      if (s0_a[15]) begin
        s1_next.x = -re_scaled;
        s1_next.y = -im_scaled;
        s1_next.z = 32'h80000000;
      end else begin
        s1_next.x = re_scaled;
        s1_next.y = im_scaled;
        s1_next.z = '0;
      end
    end else begin
      s1_next.x = rot_x;
      s1_next.y = '0;
      s1_next.z = {s0_b, 16'h0000};
      if (s0_b[15] ^ s0_b[14]) begin
        s1_next.x = -rot_x;
        s1_next.z[ZW-1] = ~s0_b[15];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0] <= '0;
    end else begin
      pipe[0] <= s1_next;
    end
  end

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
    ccc_stage #(
      .STAGE(k)
    ) u_stage (
      .clk(clk),
      .rst(rst),
      .d  (pipe[k]),
      .q  (pipe[k+1])
    );
  end

  assign fin = pipe[ITERATIONS];

  always_comb begin
    ang_sum = fin.z + 32'h00008000;
    re_sum = fin.x + $signed(XW'(1) << (FRAC - 1));
    im_sum = fin.y + $signed(XW'(1) << (FRAC - 1));
    re_sh = re_sum >>> FRAC;
    im_sh = im_sum >>> FRAC;
  end

  always_ff @(posedge clk) begin
    p1_func <= fin.func;
    p1_bypass <= fin.bypass;
    p1_im <= fin.im;
    p1_mag <= 64'(fin.x[31:0]) * 64'(GAIN_Q32);
    p1_ang <= ang_sum[31:16];
    p1_re <= re_sh[16:0];
    p1_imag <= im_sh[16:0];
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= fin.valid;
    end
  end

  always_comb begin
    mag_sum = p1_mag + (64'(1) << (MAG_SHIFT - 1));
    im_ext = 17'(p1_im);
    byp_a = p1_im[15] ? -im_ext : im_ext;
    if (p1_im == 16'sd0) begin
      byp_b = '0;
    end else if (p1_im[15]) begin
      byp_b = -17'sd16384;
    end else begin
      byp_b = 17'sd16384;
    end
    if (p1_bypass) begin
      result_a_next = byp_a;
      result_b_next = byp_b;
    end else if (p1_func == FUNC_RECT) begin
      result_a_next = p1_re;
      result_b_next = p1_imag;
    end else begin
      result_a_next = mag_sum[MAG_SHIFT+16:MAG_SHIFT];
      result_b_next = 17'(signed'(p1_ang));
    end
  end

  always_ff @(posedge clk) begin
    result_a <= result_a_next;
    result_b <= result_b_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p1_valid;
    end
  end

endmodule

// ===== rtl/ccc_checker.sv =====
// Port-level checker of the coordinate converter and its bind.
`timescale 1ns / 1ps
`include "complex_coordinate_converter_assert.svh"

module ccc_checker #(
  parameter int ITERATIONS = 16
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  localparam int LAT = ITERATIONS + 4;

  `CCC_ASSERT_ALWAYS(a_never_busy, clk, rst, !busy)
  `CCC_ASSERT_IMPLY(a_result_follows, clk, rst, start && !busy, ##LAT done)
  `CCC_ASSERT_IMPLY(a_result_has_source, clk, rst, done, $past(start && !busy, LAT))

endmodule

bind complex_coordinate_converter ccc_checker #(
  .ITERATIONS(ITERATIONS)
) u_ccc_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done)
);
